/* hdl/lkvt_pkg.sv */
// Package: sizes, operation codes, controller states and control/status bundles.
package lkvt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned KEY_BITS    = 64;
  localparam int unsigned DATA_BITS   = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OUT_CNT_W   = 5;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic load;    // capture the incoming beat
    logic search;  // register the key compare across all slots
    logic commit;  // update the table and load the result register
  } cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new beat this cycle
  } sts_t;

endpackage

/* hdl/lkvt_ctrl.sv */
// Controller: sequences capture, search and update of one table operation.
module lkvt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lkvt_pkg::sts_t sts_i,
  output lkvt_pkg::cmd_t cmd_o
);
  import lkvt_pkg::*;

  state_e state_q, state_d;
  logic   take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts_i.out_free) state_d = in_valid_i ? ST_SEARCH : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    take       = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        take = 1'b1;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
      end
      ST_UPDATE: begin
        // overlap the next capture with this commit
        take         = sts_i.out_free;
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        take = 1'b0;
      end
    endcase
    in_stall_o = !take;
    cmd_o.load = take && in_valid_i;
  end

  a_search_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |=> (state_q == ST_UPDATE))
    else $error("search not followed by update");

  a_commit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("commit while result register busy");

  a_load_not_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> !cmd_o.load)
    else $error("beat captured during search");

endmodule

/* hdl/lkvt_dpath.sv */
// Datapath: key/value slots, parallel key compare, packing remove, result register.
module lkvt_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lkvt_pkg::cmd_t                  cmd_i,
  output lkvt_pkg::sts_t                  sts_o,
  input  logic [1:0]                      operation_i,
  input  logic [63:0]                     key_i,
  input  logic [63:0]                     value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lkvt_pkg::DATA_BITS-1:0]  read_value_o,
  output logic                            found_o,
  output logic                            full_error_o,
  output logic [lkvt_pkg::OUT_CNT_W-1:0]  entry_count_o
);
  import lkvt_pkg::*;

  logic [KEY_BITS-1:0]  key_q   [TABLE_DEPTH];
  logic [DATA_BITS-1:0] val_q   [TABLE_DEPTH];
  logic [CNT_W-1:0]     count_q, count_d;

  op_e                  op_q;
  logic [KEY_BITS-1:0]  item_key_q;
  logic [DATA_BITS-1:0] item_val_q;

  logic [TABLE_DEPTH-1:0] match_d, hit_vec_q;
  logic                   hit;
  logic [IDX_W-1:0]       slot;
  logic [DATA_BITS-1:0]   hit_val;
  logic                   has_room;
  logic                   append;
  logic                   full;
  logic [DATA_BITS-1:0]   rd;

  logic                   out_valid_q;
  logic [DATA_BITS-1:0]   rd_q;
  logic                   found_q;
  logic                   full_q;
  logic [OUT_CNT_W-1:0]   cnt_out_q;

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= op_e'(operation_i);
      item_key_q <= key_i[KEY_BITS-1:0];
      item_val_q <= value_i;
    end
  end

  // Compare against every held slot
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_d[i] = (CNT_W'(i) < count_q) && (key_q[i] == item_key_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_vec_q <= '0;
    end else if (cmd_i.search) begin
      hit_vec_q <= match_d;
    end
  end

  // Keys are unique, so the hit vector is one-hot or empty
  always_comb begin
    slot    = '0;
    hit_val = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_vec_q[i]) begin
        slot    = slot | IDX_W'(i);
        hit_val = hit_val | val_q[i];
      end
    end
    hit = |hit_vec_q;
  end

  always_comb begin
    has_room = (count_q < CNT_W'(TABLE_DEPTH));
    append   = 1'b0;
    full     = 1'b0;
    rd       = '0;
    count_d  = count_q;
    unique case (op_q)
      OP_GET: begin
        if (hit) rd = hit_val;
      end
      OP_SET: begin
        if (!hit) begin
          append = has_room;
          full   = !has_room;
          if (has_room) count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (hit) count_d = count_q - CNT_W'(1);
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  // Slot storage: update in place, append at the tail, or pack down over the removed slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (op_q == OP_SET) begin
        if (hit) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit_vec_q[i]) val_q[i] <= item_val_q;
          end
        end else if (append) begin
          key_q[count_q[IDX_W-1:0]] <= item_key_q;
          val_q[count_q[IDX_W-1:0]] <= item_val_q;
        end
      end else if (op_q == OP_REMOVE && hit) begin
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
          if (IDX_W'(i) >= slot) begin
            key_q[i] <= key_q[i+1];
            val_q[i] <= val_q[i+1];
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rd_q      <= rd;
      found_q   <= (op_q != OP_CLEAR) && hit;
      full_q    <= full;
      cnt_out_q <= OUT_CNT_W'(count_d);
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign read_value_o   = rd_q;
  assign found_o        = found_q;
  assign full_error_o   = full_q;
  assign entry_count_o  = cnt_out_q;

  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec_q))
    else $error("key held in more than one slot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("pair count beyond table depth");

  a_full_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && full) |-> (!hit && count_q == CNT_W'(TABLE_DEPTH)))
    else $error("full error flagged with room or on a hit");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

endmodule

/* hdl/linear_key_value_table_core.sv */
// A result beat is presented after the search edge registers the key compare and the update edge
// commits it; the next beat is captured on that update edge, so no new beat is taken while
// one is still in search, following the search-then-update sequence of the controller.
// A stalled result holds the update step and the input until the result is taken.
// Reset (rst_ni low, asynchronous) empties the table and drops any beat in flight;
// slot contents are left as they are and only slots below the pair count are read.
module linear_key_value_table_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      operation_i,
  input  logic [63:0]                     key_i,
  input  logic [63:0]                     value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lkvt_pkg::DATA_BITS-1:0]  read_value_o,
  output logic                            found_o,
  output logic                            full_error_o,
  output logic [lkvt_pkg::OUT_CNT_W-1:0]  entry_count_o
);
  import lkvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lkvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lkvt_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .found_o       (found_o),
    .full_error_o  (full_error_o),
    .entry_count_o (entry_count_o)
  );

endmodule

/* dv/linear_key_value_table_core_test.sv */
// Testbench for linear_key_value_table_core: directed and random table traffic checked by a predictor.
module linear_key_value_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvt_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned POOL_SIZE  = 24;
  localparam int unsigned MAX_GAP    = 16;
  localparam logic [63:0] KEY_MASK   = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);

  typedef struct {
    logic [DATA_BITS-1:0] read_value;
    logic                 found;
    logic                 full_error;
    logic [OUT_CNT_W-1:0] entry_count;
  } table_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           operation_i   = OP_GET;
  logic [63:0]          key_i         = '0;
  logic [63:0]          value_i       = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [DATA_BITS-1:0] read_value_o;
  logic                 found_o;
  logic                 full_error_o;
  logic [OUT_CNT_W-1:0] entry_count_o;

  // Predicted table contents
  logic [63:0]          model_keys   [TABLE_DEPTH];
  logic [63:0]          model_values [TABLE_DEPTH];
  int unsigned          model_fill;

  table_result_t        pending_results [$];
  logic [63:0]          key_pool [POOL_SIZE];

  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          quiet_cycles = 0;

  linear_key_value_table_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .found_o       (found_o),
    .full_error_o  (full_error_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic table_result_t predict_table_op(op_e op, logic [63:0] key_raw,
                                                      logic [63:0] value);
    table_result_t res;
    logic [63:0]   key;
    int unsigned   slot;
    logic          hit;
    key  = key_raw & KEY_MASK;
    res  = '{read_value: '0, found: 1'b0, full_error: 1'b0, entry_count: '0};
    hit  = 1'b0;
    slot = 0;
    if (op == OP_CLEAR) begin
      model_fill = 0;
    end else begin
      for (int unsigned i = 0; i < model_fill; i++) begin
        if (!hit && model_keys[i] == key) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      res.found = hit;
      case (op)
        OP_GET: begin
          if (hit) res.read_value = model_values[slot];
        end
        OP_SET: begin
          if (hit) begin
            model_values[slot] = value;
          end else if (model_fill < TABLE_DEPTH) begin
            model_keys[model_fill]   = key;
            model_values[model_fill] = value;
            model_fill++;
          end else begin
            res.full_error = 1'b1;
          end
        end
        default: begin
          // Close the gap, keeping the order of the remaining pairs
          if (hit) begin
            for (int unsigned i = slot; i + 1 < model_fill; i++) begin
              model_keys[i]   = model_keys[i + 1];
              model_values[i] = model_values[i + 1];
            end
            model_fill--;
          end
        end
      endcase
    end
    res.entry_count = model_fill[OUT_CNT_W-1:0];
    return res;
  endfunction

  // Called in the time step of a rising edge; returns at the accepting edge.
  task automatic send_beat(op_e op, logic [63:0] key, logic [63:0] value);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    value_i     <= value;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    pending_results.push_back(predict_table_op(op, key, value));
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_table_ops();
    send_beat(OP_GET, 64'h0123_4567_89ab_cdef, '0);
    send_beat(OP_REMOVE, '1, '1);
    send_beat(OP_SET, '0, '0);
    send_beat(OP_SET, '1, '1);
    send_beat(OP_GET, '1, '0);
    send_beat(OP_REMOVE, '0, '1);
  endtask

  task automatic test_fill_to_capacity();
    logic [63:0] base;
    base = {$urandom, $urandom};
    send_beat(OP_CLEAR, base, '1);
    for (int unsigned i = 0; i < TABLE_DEPTH; i++)
      send_beat(OP_SET, base ^ (64'd1 << (i * 4)), {$urandom, $urandom});
    // New key on a full table: dropped with error
    send_beat(OP_SET, ~base, {$urandom, $urandom});
    // Present key on a full table: plain update
    send_beat(OP_SET, base ^ 64'd1, '1);
  endtask

  task automatic fill_key_pool();
    logic [63:0] base;
    base = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = base;
    for (int unsigned i = 3; i < 12; i++)
      key_pool[i] = base ^ (64'd1 << $urandom_range(0, 63));
    for (int unsigned i = 12; i < POOL_SIZE; i++)
      key_pool[i] = {$urandom, $urandom};
  endtask

  task automatic test_random_traffic(int unsigned n_items, int unsigned clear_pct);
    op_e         op;
    logic [63:0] key;
    logic [63:0] value;
    int unsigned roll;
    for (int unsigned n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < clear_pct) op = OP_CLEAR;
      else begin
        roll = $urandom_range(0, 99);
        op = (roll < 45) ? OP_SET : (roll < 75) ? OP_GET : OP_REMOVE;
      end
      if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      roll = $urandom_range(0, 19);
      value = (roll == 0) ? '0 : (roll == 1) ? '1 : {$urandom, $urandom};
      send_beat(op, key, value);
      if ($urandom_range(0, 199) == 0) test_drain_pause();
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    table_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: read_value=%h found=%b full_error=%b count=%0d",
                   read_value_o, found_o, full_error_o, entry_count_o);
      end else begin
        want = pending_results.pop_front();
        if (read_value_o !== want.read_value || found_o !== want.found ||
            full_error_o !== want.full_error || entry_count_o !== want.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                     want.read_value, want.found, want.full_error, want.entry_count,
                     read_value_o, found_o, full_error_o, entry_count_o);
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("linear_key_value_table_core: mismatch");
      $finish;
    end
  end

  initial begin
    model_fill = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table_ops();
    test_fill_to_capacity();
    test_drain_pause();
    fill_key_pool();

    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      test_random_traffic(205, 1);
      test_random_traffic(205, 10);
      test_drain_pause();
      fill_key_pool();
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("linear_key_value_table_core: match");
    end else begin
      $display("linear_key_value_table_core: mismatch");
    end
    $finish;
  end

endmodule
